FILE: hw/rtl/pgw_pkg.sv
// Package for the page table walker: constants, request and response words.
// No dependencies; the walker top level and the bench import it.
package pgw_pkg;

    localparam int POOL_FRAMES = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_BITS = 12;
    localparam int FRAME_W = $clog2(POOL_FRAMES);
    localparam int NF_W = $clog2(POOL_FRAMES + 1);
    localparam int ADDR_W = FRAME_W + IDX_W;
    localparam int STORE_DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
    localparam int ENTRY_W = 64;
    localparam int WORD_W = ENTRY_W + 1;
    localparam int VA_W = 48;

    localparam logic [ENTRY_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;
    localparam logic [ENTRY_W-1:0] LINK_BITS = 64'h0000_0000_0000_0003;
    localparam logic [ENTRY_W-1:0] BASE_RESET = 64'h0000_0000_0010_0000;

    localparam logic [1:0] FUNC_MAP = 2'd0;
    localparam logic [1:0] FUNC_UNMAP = 2'd1;
    localparam logic [1:0] FUNC_XLATE = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [VA_W-1:0]    virt_addr;
        logic [ENTRY_W-1:0] phys_addr;
        logic [ENTRY_W-1:0] flags;
    } pgw_req_t;

    typedef struct packed {
        logic               status;
        logic [ENTRY_W-1:0] phys_out;
    } pgw_rsp_t;

endpackage

FILE: hw/rtl/pgw_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker: sequencer, shared adder, table store.
// Depends on pgw_pkg and pgw_ram.
//
//  channel   handshake                 word
//  --------  ------------------------  -------------------------------------------
//  request   start / busy              req: func, virt_addr, phys_addr, flags
//  result    done (one-cycle strobe)   rsp: status, phys_out
//  config    cfg_valid / cfg_ready     cfg_data: pool_base
//
// Steps: each upper level takes a table read and then a check or link step;
// map and unmap then add a leaf write, translate a leaf read and its check.
// A zero base or the reserved code fails on accept. The result strobes in the cycle
// after the last step, and the next word can be taken in that same cycle.
// Reset: a clearing pass writes all POOL_FRAMES * 512 entries with busy high.
// Stalls: none; cfg_ready is always high and the receiver cannot hold results off.
module four_level_page_table_walker
    import pgw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pgw_req_t           req,
    output logic               done,
    output pgw_rsp_t           rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ENTRY_W-1:0] cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EV    = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_LEV   = 3'd5;

    localparam logic [1:0] LVL_LAST_TABLE = 2'd2;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

    logic [2:0]         state_reg, state_next;
    pgw_req_t           req_reg, req_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [NF_W-1:0]    next_free_reg, next_free_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ENTRY_W-1:0] base_reg;
    pgw_rsp_t           rsp_reg, rsp_next;
    logic               done_reg, done_next;

    logic               ram_en, ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    logic [ENTRY_W-1:0] base_addr;
    logic [IDX_W-1:0]   lvl_idx;
    logic [ADDR_W-1:0]  slot_addr;
    logic [NF_W-1:0]    next_free_inc;
    logic               frame_live, frame_live_after, pool_full;
    logic [ENTRY_W-1:0] entry;
    logic               present;
    logic [ENTRY_W-1:0] add_a, add_b, add_sum;
    logic               add_sub;
    logic               ptr_ok;
    logic [FRAME_W-1:0] ptr_frame;

    // Table store: each word carries a tag bit next to the entry. A frame reads
    // as zeroed until it is allocated; allocation flips the tag it expects, which
    // stands in for the zeroing of the whole frame.
    pgw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign base_addr = base_reg & ~PAGE_MASK;

    // Level 0..2 pick the upper table indices, level 3 is the leaf.
    always_comb
    begin
        unique case (lvl_reg)
            2'd0: lvl_idx = req_reg.virt_addr[47:39];
            2'd1: lvl_idx = req_reg.virt_addr[38:30];
            2'd2: lvl_idx = req_reg.virt_addr[29:21];
            2'd3: lvl_idx = req_reg.virt_addr[20:12];
        endcase
    end

    assign slot_addr = {frame_reg, lvl_idx};

    // A frame holds live entries once allocated; the root is live from the
    // clearing pass on with the tag cleared.
    assign next_free_inc    = next_free_reg + NF_W'(1);
    assign frame_live       = (frame_reg != '0) && (NF_W'(frame_reg) < next_free_reg);
    assign frame_live_after = (frame_reg != '0) && (NF_W'(frame_reg) < next_free_inc);
    assign pool_full        = next_free_reg >= NF_W'(POOL_FRAMES);

    assign entry   = (ram_rdata[ENTRY_W] == frame_live) ? ram_rdata[ENTRY_W-1:0] : '0;
    assign present = entry[0];

    // Shared adder: pointer offset check for a present entry, otherwise the
    // address of the frame about to be linked.
    always_comb
    begin
        add_a   = base_addr;
        add_b   = ENTRY_W'(next_free_reg) << PAGE_BITS;
        add_sub = 1'b0;
        if (state_reg == S_EV && present)
        begin
            add_a   = entry & ~PAGE_MASK;
            add_b   = base_addr;
            add_sub = 1'b1;
        end
    end

    assign add_sum   = add_a + (add_sub ? ~add_b : add_b) + ENTRY_W'(add_sub);
    assign ptr_ok    = add_sum[ENTRY_W-1:PAGE_BITS] < (ENTRY_W - PAGE_BITS)'(POOL_FRAMES);
    assign ptr_frame = add_sum[PAGE_BITS +: FRAME_W];

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        lvl_next       = lvl_reg;
        frame_next     = frame_reg;
        next_free_next = next_free_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_next       = rsp_reg;
        done_next      = 1'b0;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = slot_addr;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (base_addr == '0 || req.func == FUNC_RSVD)
                    begin
                        // Drop the request with a fail status, store untouched.
                        done_next = 1'b1;
                        rsp_next  = '{status: STATUS_FAIL, phys_out: '0};
                    end
                    else
                    begin
                        lvl_next   = '0;
                        frame_next = '0;
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                ram_en     = 1'b1;
                state_next = S_EV;
            end

            S_EV:
            begin
                if (present && !ptr_ok)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: STATUS_FAIL, phys_out: '0};
                    state_next = S_IDLE;
                end
                else if (!present && (req_reg.func != FUNC_MAP || pool_full))
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: STATUS_FAIL, phys_out: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    if (present)
                    begin
                        frame_next = ptr_frame;
                    end
                    else
                    begin
                        // Link a fresh frame as present and writable.
                        ram_en         = 1'b1;
                        ram_we         = 1'b1;
                        ram_wdata      = {frame_live_after, add_sum | LINK_BITS};
                        next_free_next = next_free_inc;
                        frame_next     = next_free_reg[FRAME_W-1:0];
                    end
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = (lvl_reg == LVL_LAST_TABLE) ? S_LEAF : S_RD;
                end
            end

            S_LEAF:
            begin
                unique case (req_reg.func)
                    FUNC_MAP:
                    begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_wdata  = {frame_live,
                                      (req_reg.phys_addr & ~PAGE_MASK) | req_reg.flags};
                        done_next  = 1'b1;
                        rsp_next   = '{status: STATUS_OK, phys_out: '0};
                        state_next = S_IDLE;
                    end
                    FUNC_UNMAP:
                    begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_wdata  = {frame_live, {ENTRY_W{1'b0}}};
                        done_next  = 1'b1;
                        rsp_next   = '{status: STATUS_OK, phys_out: '0};
                        state_next = S_IDLE;
                    end
                    FUNC_XLATE:
                    begin
                        ram_en     = 1'b1;
                        state_next = S_LEV;
                    end
                    FUNC_RSVD:
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{status: STATUS_FAIL, phys_out: '0};
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_LEV:
            begin
                done_next = 1'b1;
                if (present)
                begin
                    rsp_next = '{status: STATUS_OK,
                                 phys_out: (entry & ~PAGE_MASK) |
                                           (ENTRY_W'(req_reg.virt_addr) & PAGE_MASK)};
                end
                else
                begin
                    rsp_next = '{status: STATUS_FAIL, phys_out: '0};
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lvl_reg       <= '0;
            frame_reg     <= '0;
            next_free_reg <= NF_W'(1);
            clr_cnt_reg   <= '0;
            base_reg      <= BASE_RESET;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            frame_reg     <= frame_next;
            next_free_reg <= next_free_next;
            clr_cnt_reg   <= clr_cnt_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    // Payload words hold without reset.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Allocator stays within the pool and never drops below frame one.
    a_next_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= NF_W'(POOL_FRAMES)))
        else $error("allocator pointer out of range");

    // Only a map that links a missing level advances the allocator.
    a_alloc_only_on_map: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |->
            ($past(state_reg) == S_EV && $past(req_reg.func) == FUNC_MAP))
        else $error("allocator advanced outside a map link");

    // Back-to-back strobes only when the second word failed at once on accept.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done || $past(start && !busy)))
        else $error("result strobe repeated without a new word");

    // No result while the store is still being cleared.
    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!done && busy))
        else $error("result during clearing pass");

endmodule

FILE: tb/tb.sv
// Self-checking bench for four_level_page_table_walker: map, unmap and translate words
// against a behavioral walker with its own table store. Depends on pgw_pkg and the RTL.
`timescale 1ns / 100ps

module tb
    import pgw_pkg::*;
;

    localparam int    CLK_HALF     = 6;
    localparam int    RESET_CYCLES = 3;
    localparam int    TAIL_CYCLES  = 16;
    localparam int    GAP_MAX      = 16;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // One request word plus the idle cycles to spend before offering it.
    typedef struct {
        pgw_req_t    word;
        int unsigned gap;
    } walk_cmd_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    pgw_req_t           req       = '0;
    logic               done;
    pgw_rsp_t           rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ENTRY_W-1:0] cfg_data  = '0;

    four_level_page_table_walker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral walker: its own copy of the table pool, allocator and base.
    // ------------------------------------------------------------------
    bit [ENTRY_W-1:0] page_store [STORE_DEPTH];
    int unsigned      next_frame_m = 1;
    logic [63:0]      pool_base_m  = BASE_RESET;

    walk_cmd_t cmd_fifo [$];
    pgw_rsp_t  walk_results_due [$];

    logic word_taken = 1'b0;   // request word accepted at the last rising edge
    int   hold_left  = -1;     // idle cycles left before the head word, -1 = not drawn
    int   quiet_run_left = 0;  // words still to send back to back

    logic [IDX_W-1:0] hot_l4 [4];
    logic [IDX_W-1:0] hot_l3 [2];
    logic [IDX_W-1:0] hot_l2 [3];
    logic [IDX_W-1:0] hot_l1 [16];

    int mismatch_cnt  = 0;
    int func_cnt [4]  = '{0, 0, 0, 0};
    int ok_cnt        = 0;
    int fail_cnt      = 0;
    int cfg_writes    = 0;
    int pool_full_cnt = 0;

    // Walk levels 4..2 (allocating on map), then apply the leaf operation.
    function automatic pgw_rsp_t predict_walk(pgw_req_t r);
        logic [63:0] base;
        logic [63:0] entry;
        logic [63:0] off;
        int unsigned frame;
        int unsigned s;
        int          lvl;
        int          k;
        bit          ok;
        pgw_rsp_t    res;
        base         = pool_base_m & ~PAGE_MASK;
        res.status   = STATUS_FAIL;
        res.phys_out = '0;
        if (base == '0 || r.func == FUNC_RSVD)
            return res;
        frame = 0;
        ok    = 1'b1;
        for (lvl = 0; lvl < 3 && ok; lvl++)
        begin
            s     = frame * ENTRIES_PER_TABLE + r.virt_addr[(39 - 9 * lvl) +: IDX_W];
            entry = page_store[s];
            if (!entry[0])
            begin
                if (r.func != FUNC_MAP || next_frame_m >= POOL_FRAMES)
                begin
                    ok = 1'b0;
                    if (r.func == FUNC_MAP)
                        pool_full_cnt++;
                end
                else
                begin
                    // Fresh frame: clear it, link it present and writable.
                    for (k = 0; k < ENTRIES_PER_TABLE; k++)
                        page_store[next_frame_m * ENTRIES_PER_TABLE + k] = '0;
                    page_store[s] = (base + (64'(next_frame_m) << PAGE_BITS)) | LINK_BITS;
                    frame = next_frame_m;
                    next_frame_m++;
                end
            end
            else
            begin
                // Pointer check wraps modulo 2^64, the same as frame addresses.
                off = (entry & ~PAGE_MASK) - base;
                if ((off >> PAGE_BITS) >= 64'(POOL_FRAMES))
                    ok = 1'b0;
                else
                    frame = int'(off >> PAGE_BITS);
            end
        end
        if (ok)
        begin
            s = frame * ENTRIES_PER_TABLE + r.virt_addr[PAGE_BITS +: IDX_W];
            case (r.func)
                FUNC_MAP:
                begin
                    page_store[s] = (r.phys_addr & ~PAGE_MASK) | r.flags;
                    res.status    = STATUS_OK;
                end
                FUNC_UNMAP:
                begin
                    page_store[s] = '0;
                    res.status    = STATUS_OK;
                end
                default:
                begin
                    entry = page_store[s];
                    if (entry[0])
                    begin
                        res.phys_out = (entry & ~PAGE_MASK) |
                                       {52'd0, r.virt_addr[PAGE_BITS-1:0]};
                        res.status   = STATUS_OK;
                    end
                end
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: advance on the falling edge, hold the word until taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : request_driver
        walk_cmd_t nxt;
        logic      start_n;
        start_n = start;
        if (rst_n && (!start || word_taken))
        begin
            start_n = 1'b0;
            if (cmd_fifo.size() != 0)
            begin
                if (hold_left < 0)
                    hold_left = cmd_fifo[0].gap;
                if (hold_left > 0)
                    hold_left--;
                else
                begin
                    nxt       = cmd_fifo.pop_front();
                    req      <= nxt.word;
                    start_n   = 1'b1;
                    hold_left = -1;
                end
            end
        end
        // Single update per edge so a back-to-back word keeps start high.
        start <= start_n;
    end

    // ------------------------------------------------------------------
    // Monitor: check results, track the base register, predict taken words.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        pgw_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (rsp.status == STATUS_OK)
                    ok_cnt++;
                else
                    fail_cnt++;
                if (walk_results_due.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: status %0b phys_out %h",
                             $time, rsp.status, rsp.phys_out);
                    mismatch_cnt++;
                end
                else
                begin
                    want = walk_results_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0b actual %0b",
                                 $time, want.status, rsp.status);
                        mismatch_cnt++;
                    end
                    if (rsp.phys_out !== want.phys_out)
                    begin
                        $display("%0t: phys_out mismatch: expected %h actual %h",
                                 $time, want.phys_out, rsp.phys_out);
                        mismatch_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pool_base_m = cfg_data;
                cfg_writes++;
            end
            if (start && !busy)
            begin
                walk_results_due.push_back(predict_walk(req));
                func_cnt[req.func]++;
            end
        end
        word_taken <= rst_n && start && !busy;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one word; idle cycles are random, with occasional back-to-back runs.
    task automatic queue_request(input logic [1:0] f, input logic [VA_W-1:0] va,
                                 input logic [63:0] pa, input logic [63:0] fl);
        walk_cmd_t c;
        c.word.func      = f;
        c.word.virt_addr = va;
        c.word.phys_addr = pa;
        c.word.flags     = fl;
        if (quiet_run_left > 0)
        begin
            quiet_run_left--;
            c.gap = 0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            quiet_run_left = $urandom_range(10, 30);
            c.gap = 0;
        end
        else
            c.gap = $urandom_range(0, GAP_MAX);
        cmd_fifo.push_back(c);
    endtask

    // Mostly walks through a small set of hot table paths so maps, unmaps and
    // translates meet each other; the rest is fully random noise.
    task automatic queue_random(input int count, input int noise_pct, input int l4_pick);
        logic [1:0]      f;
        logic [VA_W-1:0] va;
        logic [63:0]     pa;
        logic [63:0]     fl;
        int              roll;
        repeat (count)
        begin
            pa = {$urandom, $urandom};
            fl = {$urandom, $urandom};
            if ($urandom_range(0, 99) < noise_pct)
            begin
                f  = 2'($urandom_range(0, 3));
                va = VA_W'({$urandom, $urandom});
            end
            else
            begin
                roll = $urandom_range(0, 99);
                f    = (roll < 40) ? FUNC_MAP : (roll < 55) ? FUNC_UNMAP : FUNC_XLATE;
                va   = {hot_l4[l4_pick + $urandom_range(0, 1)],
                        hot_l3[$urandom_range(0, 1)],
                        hot_l2[$urandom_range(0, 2)],
                        hot_l1[$urandom_range(0, 15)],
                        12'($urandom)};
                fl[0] = ($urandom_range(0, 4) != 0);
            end
            queue_request(f, va, pa, fl);
        end
    endtask

    // Hold off until every queued word is sent and every result is back.
    task automatic wait_walker_idle();
        do
            @(posedge clk);
        while (cmd_fifo.size() != 0 || start || walk_results_due.size() != 0);
    endtask

    // Write the pool base through the config channel; only called while idle.
    task automatic set_pool_base(input logic [63:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int k;
        // Spread the hot level-4 indices so the two halves never collide and
        // stay clear of the directed paths at index 0 and 511.
        for (k = 0; k < 4; k++)
            hot_l4[k] = IDX_W'(1 + 127 * k + $urandom_range(0, 120));
        for (k = 0; k < 2; k++)
            hot_l3[k] = IDX_W'($urandom);
        for (k = 0; k < 3; k++)
            hot_l2[k] = IDX_W'($urandom);
        for (k = 0; k < 16; k++)
            hot_l1[k] = IDX_W'($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty root, non-present leaf, extremes, reserved code.
        queue_request(FUNC_XLATE, 48'h0000_0000_0000, '0, '0);
        queue_request(FUNC_UNMAP, 48'h0000_0000_0000, '0, '0);
        queue_request(FUNC_MAP,   48'h0000_0000_0000, '0, '0);
        queue_request(FUNC_XLATE, 48'h0000_0000_0000, '0, '0);
        queue_request(FUNC_MAP,   48'h0000_0000_0000, 64'hFFFF_FFFF_FFFF_F123, 64'h1);
        queue_request(FUNC_XLATE, 48'h0000_0000_0ABC, '0, '0);
        queue_request(FUNC_XLATE, 48'h0000_0000_0FFF, '1, '1);
        queue_request(FUNC_MAP,   48'hFFFF_FFFF_FFFF, '1, '1);
        queue_request(FUNC_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
        queue_request(FUNC_UNMAP, 48'hFFFF_FFFF_FFFF, '1, '1);
        queue_request(FUNC_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
        queue_request(FUNC_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0);
        queue_request(FUNC_UNMAP, 48'h0000_0000_1000, '0, '0);
        queue_request(FUNC_RSVD,  48'h0000_0000_0000, '1, '1);
        queue_request(FUNC_RSVD,  48'hFFFF_FFFF_FFFF, '0, '0);
        queue_request(FUNC_MAP,   48'h0000_0000_1000, 64'h1234_5678_9ABC_D000,
                      64'h8000_0000_0000_0003);
        queue_request(FUNC_XLATE, 48'h0000_0000_1FFF, '0, '0);
        queue_request(FUNC_MAP,   48'h0000_0020_0000, 64'h5000, 64'h1);
        queue_request(FUNC_XLATE, 48'h0000_0020_0123, '0, '0);
        queue_request(FUNC_XLATE, 48'h0000_4000_0000, '0, '0);
        queue_request(FUNC_XLATE, 48'h0080_0000_0000, '0, '0);
        queue_request(FUNC_MAP,   48'h0000_0000_0000, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_request(FUNC_XLATE, 48'h0000_0000_0000, '0, '0);
        wait_walker_idle();

        // Top-of-space base: new frame addresses wrap past 2^64; use the
        // second hot half so these links never shadow the reset-base paths.
        set_pool_base('1);
        queue_random(60, 0, 2);
        wait_walker_idle();

        // Back to the reset base with junk in the ignored low bits; the long
        // run here drains the frame pool.
        set_pool_base(BASE_RESET | PAGE_MASK);
        queue_random(500, 10, 0);
        wait_walker_idle();

        // No root: only low bits, then all zero.
        set_pool_base(PAGE_MASK);
        queue_random(20, 30, 0);
        wait_walker_idle();
        set_pool_base('0);
        queue_random(20, 30, 0);
        wait_walker_idle();

        // Shift the pool past its old frames: every old link is a bad pointer.
        set_pool_base(BASE_RESET + (64'(POOL_FRAMES) << PAGE_BITS));
        queue_random(100, 15, 0);
        wait_walker_idle();

        set_pool_base({$urandom, $urandom});
        queue_random(100, 15, 0);
        wait_walker_idle();

        set_pool_base(BASE_RESET);
        queue_random(430, 10, 0);
        wait_walker_idle();

        // Let any stray strobe show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (walk_results_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, walk_results_due.size());
            mismatch_cnt++;
        end

        $display("Covered %0d words (%0d map, %0d unmap, %0d translate, %0d reserved): %0d ok, %0d failed.",
                 func_cnt[0] + func_cnt[1] + func_cnt[2] + func_cnt[3],
                 func_cnt[FUNC_MAP], func_cnt[FUNC_UNMAP], func_cnt[FUNC_XLATE],
                 func_cnt[FUNC_RSVD], ok_cnt, fail_cnt);
        $display("%0d pool base writes, %0d of %0d frames allocated, %0d maps hit a full pool.",
                 cfg_writes, next_frame_m, POOL_FRAMES, pool_full_cnt);
        if (mismatch_cnt == 0)
            $display("** four_level_page_table_walker: PASSED **");
        else
            $display("** four_level_page_table_walker: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest legal run, reset clearing pass included.
    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("** four_level_page_table_walker: FAILED **");
        $finish;
    end

endmodule
